### rtl/esmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esmf_pkg
// Shared types and constants for the encoder speed measurement filter.
// ----------------------------------------------------------------------------
package esmf_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned WIDE_W   = 64;
    localparam int unsigned TICK_W   = 8;
    localparam int unsigned MIND_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Q0.32 filter constants
    localparam logic [DATA_W-1:0] INV_GAIN_Q32 = 32'd652364;
    localparam logic [DATA_W-1:0] COEF_Q32     = 32'd4293662567;

    localparam logic [DATA_W-1:0] SCALE_RST     = 32'd19660800;
    localparam logic [MIND_W-1:0] MIN_DELTA_RST = 16'd50;
    localparam logic [TICK_W-1:0] MAX_TICKS_RST = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DELTA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TICKS   = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage
`default_nettype wire

### rtl/esmf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esmf_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module esmf_mul
(
    input  wire logic                           clk,
    input  wire logic [esmf_pkg::DATA_W-1:0]    a,
    input  wire logic [esmf_pkg::DATA_W-1:0]    b,
    output logic      [esmf_pkg::WIDE_W-1:0]    p
);

    logic [esmf_pkg::WIDE_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= {{esmf_pkg::DATA_W{1'b0}}, a} * {{esmf_pkg::DATA_W{1'b0}}, b};
    end

    assign p = p_reg;

endmodule
`default_nettype wire

### rtl/esmf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esmf_div
// Restoring divider, 64-bit dividend by 8-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module esmf_div
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [esmf_pkg::WIDE_W-1:0]    dividend,
    input  wire logic [esmf_pkg::TICK_W-1:0]    divisor,
    output logic      [esmf_pkg::WIDE_W-1:0]    quotient,
    output esmf_pkg::div_status_t               status
);

    localparam int unsigned CNT_W = $clog2(esmf_pkg::WIDE_W);

    logic                           busy_reg;
    logic                           done_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [esmf_pkg::WIDE_W-1:0]    q_reg;
    logic [esmf_pkg::TICK_W-1:0]    rem_reg;
    logic [esmf_pkg::TICK_W-1:0]    d_reg;
    logic [esmf_pkg::TICK_W:0]      rem_sh;
    logic [esmf_pkg::TICK_W:0]      rem_sub;
    logic                           ge;

    assign rem_sh  = {rem_reg, q_reg[esmf_pkg::WIDE_W-1]};
    assign ge      = rem_sh >= {1'b0, d_reg};
    assign rem_sub = rem_sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(esmf_pkg::WIDE_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[esmf_pkg::WIDE_W-2:0], ge};
            rem_reg <= ge ? rem_sub[esmf_pkg::TICK_W-1:0] : rem_sh[esmf_pkg::TICK_W-1:0];
        end
    end

    assign quotient    = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

### rtl/encoder_speed_measure_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_speed_measure_filter
// M/T encoder speed measurement with a first-order lowpass on the result.
// ----------------------------------------------------------------------------
// Path: a transaction that recomputes the speed passes through the multiply, the
//   bit-serial divider and the filter update; otherwise only the filter update.
// Flow: the sequencer and the shared multiplier serve one transaction at a time.
// Reset: asynchronous, active low; clears the sequencer, saved position, tick
//   count, held speed, filter history and output valid, and loads the register
//   defaults (scale 19660800, min delta 50, max ticks 10).
// ----------------------------------------------------------------------------
module encoder_speed_measure_filter
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [esmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [esmf_pkg::DATA_W-1:0]        cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [esmf_pkg::DATA_W-1:0]        position,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [esmf_pkg::DATA_W-1:0]      speed,
    output logic signed [esmf_pkg::DATA_W-1:0]      speed_filtered,
    output logic                                    updated
);

    localparam int unsigned DW = esmf_pkg::DATA_W;
    localparam int unsigned WW = esmf_pkg::WIDE_W;
    localparam int unsigned TW = esmf_pkg::TICK_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MULS  = 4'd1;
    localparam logic [3:0] S_DIVGO = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_MULX  = 4'd4;
    localparam logic [3:0] S_MULLO = 4'd5;
    localparam logic [3:0] S_MULHI = 4'd6;
    localparam logic [3:0] S_ADDC  = 4'd7;
    localparam logic [3:0] S_NEG   = 4'd8;
    localparam logic [3:0] S_SUM   = 4'd9;
    localparam logic [3:0] S_RND   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    function automatic logic [WW-1:0] sat_add(input logic [WW-1:0] a, input logic [WW-1:0] b);
        logic [WW:0] s;
        s = {a[WW-1], a} + {b[WW-1], b};
        if (s[WW] != s[WW-1])
            sat_add = s[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
        else
            sat_add = s[WW-1:0];
    endfunction

    // configuration
    logic [DW-1:0]                  scale_reg;
    logic [esmf_pkg::MIND_W-1:0]    min_delta_reg;
    logic [TW-1:0]                  max_ticks_reg;

    // state
    logic [3:0]         state_reg;
    logic [3:0]         state_next;
    logic [DW-1:0]      saved_pos_reg;
    logic [TW-1:0]      tick_count_reg;
    logic [DW-1:0]      held_speed_reg;
    logic [WW-1:0]      x_prev_reg;
    logic [WW-1:0]      y_prev_reg;

    // working registers
    logic [DW-1:0]      pos_reg;
    logic [DW-1:0]      mag_reg;
    logic               neg_reg;
    logic               upd_reg;
    logic [WW-1:0]      x_reg;
    logic [DW-1:0]      acc_reg;
    logic [WW-1:0]      p_reg;
    logic [WW-1:0]      t_reg;
    logic [WW-1:0]      c_reg;
    logic [DW-1:0]      filt_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DW-1:0]      speed_reg;
    logic [DW-1:0]      speed_filt_reg;
    logic               updated_reg;

    // datapath signals
    logic               in_acc;
    logic               out_acc;
    logic [DW-1:0]      diff;
    logic               diff_neg;
    logic [DW-1:0]      diff_mag;
    logic [TW-1:0]      tick_next;
    logic               upd_now;
    logic [DW-1:0]      mul_a;
    logic [DW-1:0]      mul_b;
    logic [WW-1:0]      mul_p;
    logic               div_start;
    logic [WW-1:0]      div_q;
    esmf_pkg::div_status_t div_st;
    logic [DW-1:0]      held_next;
    logic [DW-1:0]      held_mag;
    logic [WW-1:0]      y_mag;
    logic [WW:0]        rnd_sum;
    logic [DW:0]        rnd_q;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    assign out_valid_next = ((state_reg == S_OUT) && (!out_valid_reg || !out_stall))
                         || (out_valid_reg && !out_acc);

    assign diff      = position - saved_pos_reg;
    assign diff_neg  = diff[DW-1];
    assign diff_mag  = diff_neg ? (~diff + 1'b1) : diff;
    assign tick_next = (tick_count_reg == {TW{1'b1}}) ? tick_count_reg
                                                      : tick_count_reg + 1'b1;
    assign upd_now   = (diff_mag >= {{(DW-esmf_pkg::MIND_W){1'b0}}, min_delta_reg})
                    || (tick_next >= max_ticks_reg);

    assign held_mag  = held_speed_reg[DW-1] ? (~held_speed_reg + 1'b1) : held_speed_reg;
    assign y_mag     = y_prev_reg[WW-1] ? (~y_prev_reg + 1'b1) : y_prev_reg;

    always_comb
    begin
        if (neg_reg)
            held_next = (div_q >= 64'h0000_0000_8000_0000) ? {1'b1, {(DW-1){1'b0}}}
                                                          : (~div_q[DW-1:0] + 1'b1);
        else
            held_next = (div_q >= 64'h0000_0000_7FFF_FFFF) ? {1'b0, {(DW-1){1'b1}}}
                                                          : div_q[DW-1:0];
    end

    assign rnd_sum = {y_prev_reg[WW-1], y_prev_reg} + {{(WW-DW+1){1'b0}}, 1'b1, {(DW-1){1'b0}}};
    assign rnd_q   = rnd_sum[WW:WW-DW];

    always_comb
    begin
        unique case (state_reg)
            S_MULS:
            begin
                mul_a = mag_reg;
                mul_b = scale_reg;
            end
            S_MULX:
            begin
                mul_a = held_mag;
                mul_b = esmf_pkg::INV_GAIN_Q32;
            end
            S_MULLO:
            begin
                mul_a = y_mag[DW-1:0];
                mul_b = esmf_pkg::COEF_Q32;
            end
            S_MULHI:
            begin
                mul_a = y_mag[WW-1:DW];
                mul_b = esmf_pkg::COEF_Q32;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_start = (state_reg == S_DIVGO);

    esmf_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    esmf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_p),
        .divisor  (tick_count_reg),
        .quotient (div_q),
        .status   (div_st)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_acc) state_next = upd_now ? S_MULS : S_MULX;
            S_MULS:  state_next = S_DIVGO;
            S_DIVGO: state_next = S_DIV;
            S_DIV:   if (div_st.done) state_next = S_MULX;
            S_MULX:  state_next = S_MULLO;
            S_MULLO: state_next = S_MULHI;
            S_MULHI: state_next = S_ADDC;
            S_ADDC:  state_next = S_NEG;
            S_NEG:   state_next = S_SUM;
            S_SUM:   state_next = S_RND;
            S_RND:   state_next = S_OUT;
            S_OUT:   if (!out_valid_reg || !out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= esmf_pkg::SCALE_RST;
            min_delta_reg <= esmf_pkg::MIN_DELTA_RST;
            max_ticks_reg <= esmf_pkg::MAX_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                esmf_pkg::REG_SPEED_SCALE: scale_reg     <= cfg_data;
                esmf_pkg::REG_MIN_DELTA:   min_delta_reg <= cfg_data[esmf_pkg::MIND_W-1:0];
                esmf_pkg::REG_MAX_TICKS:   max_ticks_reg <= cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            saved_pos_reg  <= '0;
            tick_count_reg <= '0;
            held_speed_reg <= '0;
            x_prev_reg     <= '0;
            y_prev_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                        tick_count_reg <= tick_next;
                end
                S_DIV:
                begin
                    if (div_st.done)
                    begin
                        held_speed_reg <= held_next;
                        saved_pos_reg  <= pos_reg;
                        tick_count_reg <= '0;
                    end
                end
                S_SUM:
                begin
                    y_prev_reg <= sat_add(t_reg, c_reg);
                    x_prev_reg <= x_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                pos_reg <= position;
                mag_reg <= diff_mag;
                neg_reg <= diff_neg;
                upd_reg <= upd_now;
            end
            S_MULLO:
            begin
                x_reg <= held_speed_reg[DW-1] ? (~mul_p + 1'b1) : mul_p;
            end
            S_MULHI:
            begin
                acc_reg <= mul_p[WW-1:DW];
            end
            S_ADDC:
            begin
                p_reg <= mul_p + {{(WW-DW){1'b0}}, acc_reg};
                t_reg <= sat_add(x_prev_reg, x_reg);
            end
            S_NEG:
            begin
                c_reg <= y_prev_reg[WW-1] ? (~p_reg + 1'b1) : p_reg;
            end
            S_RND:
            begin
                if (rnd_q[DW] != rnd_q[DW-1])
                    filt_reg <= rnd_q[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
                else
                    filt_reg <= rnd_q[DW-1:0];
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    speed_reg      <= held_speed_reg;
                    speed_filt_reg <= filt_reg;
                    updated_reg    <= upd_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign speed          = speed_reg;
    assign speed_filtered = speed_filt_reg;
    assign updated        = updated_reg;

`ifndef NO_ASSERTIONS
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_DIV))
        else $error("divider done outside wait state");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (tick_count_reg != '0))
        else $error("division started with zero tick count");

    a_tick_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_st.done) |=> (tick_count_reg == '0))
        else $error("tick count not cleared after speed update");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !(out_valid_reg && out_stall)) |=> out_valid_reg)
        else $error("result not presented");

    a_div_idle_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MULX) |-> !div_st.busy)
        else $error("divider still busy during filter update");
`endif

endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the encoder speed measurement filter.
// A queue-fed driver sends encoder positions, and a transaction-level predictor
// models the M/T speed update and the Q16.48 lowpass. A monitor compares
// each result transaction field by field. The run goes through several
// register settings and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [31:0] speed;
        logic [31:0] speed_filtered;
        logic        updated;
    } speed_result_t;

    localparam int                 LIMIT       = 1000000;
    localparam int                 DRAIN_WAIT  = 100;
    localparam int                 PHASE_ITEMS = 212;
    localparam logic signed [63:0] GAIN_RECIP  = 64'sd652364;
    localparam logic [63:0]        LP_COEF     = 64'd4293662567;
    localparam logic signed [63:0] S64_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN     = 64'sh8000_0000_0000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [esmf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [esmf_pkg::DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [esmf_pkg::DATA_W-1:0] position = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [esmf_pkg::DATA_W-1:0] speed;
    logic signed [esmf_pkg::DATA_W-1:0] speed_filtered;
    logic updated;

    encoder_speed_measure_filter uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .position       (position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .speed          (speed),
        .speed_filtered (speed_filtered),
        .updated        (updated)
    );

    // predictor copy of registers and state
    logic [31:0]        scale_reg = 32'd19660800;
    logic [15:0]        min_delta_reg = 16'd50;
    logic [7:0]         max_ticks_reg = 8'd10;
    logic [31:0]        saved_pos = '0;
    logic [7:0]         tick_cnt = '0;
    logic [31:0]        held_speed = '0;
    logic signed [63:0] lp_x_prev = '0;
    logic signed [63:0] lp_y_prev = '0;

    logic [31:0]   pending_positions[$];
    speed_result_t expected_results[$];

    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          err_count = 0;
    int          cycle_count = 0;
    logic        in_fire = 1'b0;
    logic [31:0] gen_pos = '0;
    int          gen_vel = 0;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    // COEF * y in Q16.48, magnitude truncated
    function automatic logic signed [63:0] coef_scale(input logic signed [63:0] y);
        logic [63:0] m;
        logic [63:0] p;
        m = y[63] ? 64'd0 - y : y;
        p = (m >> 32) * LP_COEF + (((m & 64'hFFFF_FFFF) * LP_COEF) >> 32);
        return y[63] ? 64'd0 - p : p;
    endfunction

    function automatic logic [31:0] round_to_q16(input logic signed [63:0] y);
        logic [64:0] t;
        t = {y[63], y} + 65'h0_8000_0000;
        if (t[64] != t[63])
            return t[64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return t[63:32];
    endfunction

    function automatic speed_result_t predict_tick(input logic [31:0] pos);
        speed_result_t r;
        logic [31:0]        diff;
        logic [31:0]        mag;
        logic               neg;
        logic               upd;
        logic [63:0]        q;
        logic signed [63:0] x;
        logic signed [63:0] y;
        diff = pos - saved_pos;
        neg = diff[31];
        mag = neg ? 32'd0 - diff : diff;
        if (tick_cnt != 8'hFF)
            tick_cnt = tick_cnt + 8'd1;
        upd = (mag >= {16'd0, min_delta_reg}) || (tick_cnt >= max_ticks_reg);
        if (upd)
        begin
            q = ({32'd0, mag} * {32'd0, scale_reg}) / {56'd0, tick_cnt};
            if (neg)
                held_speed = (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - q[31:0];
            else
                held_speed = (q >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
            saved_pos = pos;
            tick_cnt = '0;
        end
        x = $signed({{32{held_speed[31]}}, held_speed}) * GAIN_RECIP;
        y = sat_sum(sat_sum(lp_x_prev, x), coef_scale(lp_y_prev));
        lp_x_prev = x;
        lp_y_prev = y;
        r.speed = held_speed;
        r.speed_filtered = round_to_q16(y);
        r.updated = upd;
        return r;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_positions.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                in_valid <= 1'b1;
                position <= pending_positions.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < snk_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        speed_result_t want;
        in_fire <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: result transaction with none pending", $time);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (speed !== want.speed || speed_filtered !== want.speed_filtered
                        || updated !== want.updated)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("%0t: exp speed %h filt %h upd %b, got %h %h %b",
                                     $time, want.speed, want.speed_filtered,
                                     want.updated, speed, speed_filtered, updated);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(predict_tick(position));
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [esmf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            esmf_pkg::REG_SPEED_SCALE: scale_reg = data;
            esmf_pkg::REG_MIN_DELTA:   min_delta_reg = data[15:0];
            esmf_pkg::REG_MAX_TICKS:   max_ticks_reg = data[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic [31:0] scale, input logic [15:0] min_d,
                                 input logic [7:0] max_t);
        write_reg(esmf_pkg::REG_SPEED_SCALE, scale);
        write_reg(esmf_pkg::REG_MIN_DELTA, {16'd0, min_d});
        write_reg(esmf_pkg::REG_MAX_TICKS, {24'd0, max_t});
    endtask

    task automatic wait_drain();
        while (pending_positions.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // mostly steady motion around the trigger threshold, plus jumps and noise
    task automatic add_random_items(input int n);
        int          sel;
        int          span;
        logic [31:0] step;
        span = int'(min_delta_reg) + 2;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 50)
            begin
                if (i == 0 || $urandom_range(0, 9) == 0)
                    gen_vel = $urandom_range(0, 2 * span) - span;
                gen_pos = gen_pos + gen_vel;
            end
            else if (sel < 65)
            begin
                step = {16'd0, min_delta_reg} - $urandom_range(0, 1);
                gen_pos = $urandom_range(0, 1) ? gen_pos - step : gen_pos + step;
            end
            else if (sel < 75)
                gen_pos = gen_pos;
            else if (sel < 85)
                gen_pos = $urandom;
            else if (sel < 90)
                gen_pos = gen_pos + 32'h8000_0000;
            else if (sel < 95)
                gen_pos = gen_pos + ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0001);
            else
                gen_pos = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            pending_positions.push_back(gen_pos);
        end
    endtask

    initial
    begin
        logic [31:0] scale_tab[8];
        logic [15:0] min_tab[8];
        logic [7:0]  max_tab[8];
        int          src_tab[4];
        int          snk_tab[4];
        scale_tab = '{32'd19660800, 32'hFFFF_FFFF, 32'd0, 32'd1,
                      $urandom, 32'd65536, $urandom, 32'hFFFF_FFFF};
        min_tab = '{16'd50, 16'd0, 16'hFFFF, 16'd1,
                    16'($urandom_range(0, 300)), 16'd200, 16'($urandom), 16'hFFFF};
        max_tab = '{8'd10, 8'd1, 8'hFF, 8'd0,
                    8'($urandom_range(1, 40)), 8'd50, 8'($urandom), 8'hFF};
        src_tab = '{0, 70, 0, 21};
        snk_tab = '{0, 0, 70, 21};

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: threshold edge, most negative delta, saturation, wrap,
        // forced update after max ticks
        pending_positions.push_back(32'h0000_0000);
        pending_positions.push_back(32'd49);
        pending_positions.push_back(32'd50);
        pending_positions.push_back(32'h8000_0032);
        pending_positions.push_back(32'h0000_0031);
        pending_positions.push_back(32'hFFFF_FFFF);
        repeat (10) pending_positions.push_back(32'h0000_0000);
        pending_positions.push_back(32'hAAAA_AAAA);
        pending_positions.push_back(32'h5555_5555);
        wait_drain();

        gen_pos = 32'h5555_5555;
        for (int p = 0; p < 8; p++)
        begin
            apply_setting(scale_tab[p], min_tab[p], max_tab[p]);
            src_idle_pct = src_tab[p % 4];
            snk_stall_pct = snk_tab[p % 4];
            add_random_items(PHASE_ITEMS);
            wait_drain();
        end

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
